// ----- hdl/aeg_pkg.sv -----
// shared constants and types for the adsr envelope generator
`default_nettype none
package aeg_pkg;

  // default number of fraction bits of the level, coefficients and offsets
  localparam int FRAC_BITS_DEF = 16;

  // stage codes
  localparam int STAGE_W = 3;
  localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
  localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
  localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
  localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;

  // configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int IDX_W  = 3;
  localparam logic [IDX_W-1:0] CFG_ATTACK_OFFSET  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ATTACK_COEFF   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_DECAY_OFFSET   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_DECAY_COEFF    = 3'd3;
  localparam logic [IDX_W-1:0] CFG_SUSTAIN_LEVEL  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_RELEASE_OFFSET = 3'd5;
  localparam logic [IDX_W-1:0] CFG_RELEASE_COEFF  = 3'd6;

  // register reset values in Q1.16, scaled to the configured fraction width
  localparam longint RST_ATTACK_OFFSET_Q16  = 656;
  localparam longint RST_ATTACK_COEFF_Q16   = 65536;
  localparam longint RST_DECAY_OFFSET_Q16   = -328;
  localparam longint RST_DECAY_COEFF_Q16    = 65536;
  localparam longint RST_SUSTAIN_LEVEL_Q16  = 32768;
  localparam longint RST_RELEASE_OFFSET_Q16 = -328;
  localparam longint RST_RELEASE_COEFF_Q16  = 65536;

  // gate edges seen by the input stage
  typedef struct packed {
    logic rise;
    logic fall;
  } gate_ev_t;

endpackage
`default_nettype wire

// ----- hdl/aeg_cfg_regs.sv -----
// configuration registers behind the apb-style port
`default_nettype none
module aeg_cfg_regs #(
  parameter int FRAC_BITS = aeg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [aeg_pkg::APB_AW-1:0] paddr,
  input  wire logic [aeg_pkg::APB_DW-1:0] pwdata,
  output logic      [aeg_pkg::APB_DW-1:0] prdata,
  output logic signed [FRAC_BITS+1:0]     attack_offset,
  output logic      [FRAC_BITS:0]         attack_coeff,
  output logic signed [FRAC_BITS+1:0]     decay_offset,
  output logic      [FRAC_BITS:0]         decay_coeff,
  output logic      [FRAC_BITS:0]         sustain_level,
  output logic signed [FRAC_BITS+1:0]     release_offset,
  output logic      [FRAC_BITS:0]         release_coeff
);
  import aeg_pkg::*;

  localparam int LW = FRAC_BITS + 1;
  localparam int OW = FRAC_BITS + 2;
  localparam longint SCALE = longint'(1) << FRAC_BITS;

  localparam logic [OW-1:0] AO_RST = OW'((RST_ATTACK_OFFSET_Q16 * SCALE) / 65536);
  localparam logic [LW-1:0] AC_RST = LW'((RST_ATTACK_COEFF_Q16 * SCALE) / 65536);
  localparam logic [OW-1:0] DO_RST = OW'((RST_DECAY_OFFSET_Q16 * SCALE) / 65536);
  localparam logic [LW-1:0] DC_RST = LW'((RST_DECAY_COEFF_Q16 * SCALE) / 65536);
  localparam logic [LW-1:0] SL_RST = LW'((RST_SUSTAIN_LEVEL_Q16 * SCALE) / 65536);
  localparam logic [OW-1:0] RO_RST = OW'((RST_RELEASE_OFFSET_Q16 * SCALE) / 65536);
  localparam logic [LW-1:0] RC_RST = LW'((RST_RELEASE_COEFF_Q16 * SCALE) / 65536);

  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[IDX_W+1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_offset  <= AO_RST;
      attack_coeff   <= AC_RST;
      decay_offset   <= DO_RST;
      decay_coeff    <= DC_RST;
      sustain_level  <= SL_RST;
      release_offset <= RO_RST;
      release_coeff  <= RC_RST;
    end else if (wr_en) begin
      case (idx)
        CFG_ATTACK_OFFSET:  attack_offset  <= pwdata[OW-1:0];
        CFG_ATTACK_COEFF:   attack_coeff   <= pwdata[LW-1:0];
        CFG_DECAY_OFFSET:   decay_offset   <= pwdata[OW-1:0];
        CFG_DECAY_COEFF:    decay_coeff    <= pwdata[LW-1:0];
        CFG_SUSTAIN_LEVEL:  sustain_level  <= pwdata[LW-1:0];
        CFG_RELEASE_OFFSET: release_offset <= pwdata[OW-1:0];
        CFG_RELEASE_COEFF:  release_coeff  <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_ATTACK_OFFSET:  prdata = APB_DW'(attack_offset);
      CFG_ATTACK_COEFF:   prdata = APB_DW'(attack_coeff);
      CFG_DECAY_OFFSET:   prdata = APB_DW'(decay_offset);
      CFG_DECAY_COEFF:    prdata = APB_DW'(decay_coeff);
      CFG_SUSTAIN_LEVEL:  prdata = APB_DW'(sustain_level);
      CFG_RELEASE_OFFSET: prdata = APB_DW'(release_offset);
      CFG_RELEASE_COEFF:  prdata = APB_DW'(release_coeff);
      default:            prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/aeg_input_stage.sv -----
// input register with gate edge detection
`default_nettype none
module aeg_input_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              gate,
  input  wire logic              take,
  output logic                   s1_valid,
  output aeg_pkg::gate_ev_t      ev
);
  import aeg_pkg::*;

  logic last_gate;

  assign in_ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      last_gate <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid  <= 1'b1;
        last_gate <= gate;
      end else if (take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // edges are taken against the previous word's gate
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev.rise <= gate && !last_gate;
      ev.fall <= !gate && last_gate;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/aeg_core.sv -----
// stage sequencing and the level multiply-add with saturation
`default_nettype none
module aeg_core #(
  parameter int FRAC_BITS = aeg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s1_valid,
  input  wire aeg_pkg::gate_ev_t             ev,
  output logic                               take,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [FRAC_BITS:0]            level,
  output logic      [aeg_pkg::STAGE_W-1:0]   stage,
  input  wire logic signed [FRAC_BITS+1:0]   attack_offset,
  input  wire logic      [FRAC_BITS:0]       attack_coeff,
  input  wire logic signed [FRAC_BITS+1:0]   decay_offset,
  input  wire logic      [FRAC_BITS:0]       decay_coeff,
  input  wire logic      [FRAC_BITS:0]       sustain_level,
  input  wire logic signed [FRAC_BITS+1:0]   release_offset,
  input  wire logic      [FRAC_BITS:0]       release_coeff
);
  import aeg_pkg::*;

  localparam int LW = FRAC_BITS + 1;
  localparam int OW = FRAC_BITS + 2;
  localparam int SW = FRAC_BITS + 3;
  localparam int PW = 2 * FRAC_BITS + 2;
  localparam logic [LW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [STAGE_W-1:0]   stage_reg;
  logic [LW-1:0]        level_reg;
  logic [STAGE_W-1:0]   stage_next;
  logic [LW-1:0]        level_next;
  logic [STAGE_W-1:0]   eff_stage;
  logic [LW-1:0]        coeff;
  logic signed [OW-1:0] offs;
  logic [LW-1:0]        sus;
  logic [PW-1:0]        prod;
  logic [OW-1:0]        t_raw;
  logic [LW-1:0]        t_sat;
  logic signed [SW-1:0] sum;
  logic [LW-1:0]        s_sat;

  assign take  = s1_valid && (!out_valid || out_ready);
  assign level = level_reg;
  assign stage = stage_reg;

  // edge decides the stage used for this word
  always_comb begin
    if (ev.rise) begin
      eff_stage = ST_ATTACK;
    end else if (ev.fall && stage_reg != ST_IDLE) begin
      eff_stage = ST_RELEASE;
    end else begin
      eff_stage = stage_reg;
    end
  end

  always_comb begin
    case (eff_stage)
      ST_ATTACK: begin
        coeff = attack_coeff;
        offs  = attack_offset;
      end
      ST_DECAY: begin
        coeff = decay_coeff;
        offs  = decay_offset;
      end
      default: begin
        coeff = release_coeff;
        offs  = release_offset;
      end
    endcase
  end

  assign sus   = (sustain_level > ONE) ? ONE : sustain_level;
  assign prod  = level_reg * coeff;
  assign t_raw = prod[PW-1:FRAC_BITS];
  assign t_sat = (t_raw > OW'(ONE)) ? ONE : t_raw[LW-1:0];
  assign sum   = $signed({2'b00, t_sat}) + SW'(offs);

  always_comb begin
    if (sum < 0) begin
      s_sat = '0;
    end else if (sum > $signed({2'b00, ONE})) begin
      s_sat = ONE;
    end else begin
      s_sat = sum[LW-1:0];
    end
  end

  always_comb begin
    stage_next = eff_stage;
    level_next = level_reg;
    case (eff_stage)
      ST_ATTACK: begin
        level_next = s_sat;
        if (s_sat >= ONE) begin
          level_next = ONE;
          stage_next = ST_DECAY;
        end
      end
      ST_DECAY: begin
        level_next = s_sat;
        if (s_sat <= sus) begin
          level_next = sus;
          stage_next = ST_SUSTAIN;
        end
      end
      ST_RELEASE: begin
        level_next = s_sat;
        if (s_sat == '0) begin
          stage_next = ST_IDLE;
        end
      end
      default: ;
    endcase
  end

  // the state registers double as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg <= ST_IDLE;
      level_reg <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        stage_reg <= stage_next;
        level_reg <= level_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/adsr_envelope_generator_unit.sv -----
// adsr envelope generator top level
// a word accepted passes the input register, then the state registers, to the output
// throughput: one word per cycle with out_ready high; multiply-add is combinational
// while the result waits on out_ready the input register holds one more word, then stalls
// reset (rst, synchronous) clears the stage to idle, the level and last gate to 0
// and loads the configuration registers with their default values
`default_nettype none
module adsr_envelope_generator_unit #(
  parameter int FRAC_BITS = aeg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       gate,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [FRAC_BITS:0]              level,
  output logic [aeg_pkg::STAGE_W-1:0]     stage,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [aeg_pkg::APB_AW-1:0] paddr,
  input  wire logic [aeg_pkg::APB_DW-1:0] pwdata,
  output logic      [aeg_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import aeg_pkg::*;

  logic signed [FRAC_BITS+1:0] attack_offset;
  logic        [FRAC_BITS:0]   attack_coeff;
  logic signed [FRAC_BITS+1:0] decay_offset;
  logic        [FRAC_BITS:0]   decay_coeff;
  logic        [FRAC_BITS:0]   sustain_level;
  logic signed [FRAC_BITS+1:0] release_offset;
  logic        [FRAC_BITS:0]   release_coeff;
  logic                        s1_valid;
  logic                        take;
  gate_ev_t                    ev;

  assign pready = 1'b1;

  aeg_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .attack_offset  (attack_offset),
    .attack_coeff   (attack_coeff),
    .decay_offset   (decay_offset),
    .decay_coeff    (decay_coeff),
    .sustain_level  (sustain_level),
    .release_offset (release_offset),
    .release_coeff  (release_coeff)
  );

  aeg_input_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .gate     (gate),
    .take     (take),
    .s1_valid (s1_valid),
    .ev       (ev)
  );

  aeg_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk            (clk),
    .rst            (rst),
    .s1_valid       (s1_valid),
    .ev             (ev),
    .take           (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .level          (level),
    .stage          (stage),
    .attack_offset  (attack_offset),
    .attack_coeff   (attack_coeff),
    .decay_offset   (decay_offset),
    .decay_coeff    (decay_coeff),
    .sustain_level  (sustain_level),
    .release_offset (release_offset),
    .release_coeff  (release_coeff)
  );

endmodule
`default_nettype wire

// ----- hdl/aeg_checker.sv -----
// port-level checks for the adsr envelope generator, bound to the top level
`default_nettype none
module aeg_checker #(
  parameter int FRAC_BITS = aeg_pkg::FRAC_BITS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [FRAC_BITS:0]          level,
  input wire logic [aeg_pkg::STAGE_W-1:0] stage
);
  import aeg_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level) && $stable(stage))
    else $error("result word changed while stalled");

  // level never exceeds 1.0
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!level[FRAC_BITS] || level[FRAC_BITS-1:0] == '0))
    else $error("level above one");

  // idle always sits at zero
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && stage == ST_IDLE |-> level == '0)
    else $error("nonzero level in idle");

  // a word accepted while no result is held passes the input register, then the state registers, to the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after accepted word");

endmodule

bind adsr_envelope_generator_unit aeg_checker #(.FRAC_BITS(FRAC_BITS)) u_aeg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .level     (level),
  .stage     (stage)
);
`default_nettype wire
